[rtl/core/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// LFU replacement package
// Shared widths, constants and the queue entry type of the replacement core.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int SETS = 2048;
   localparam int WAYS = 16;
   localparam int SET_W = 11;
   localparam int WAY_W = 4;
   localparam int WAYS_W = $clog2(WAYS);
   localparam int CNT_W = 32;
   localparam int STAMP_W = 48;
   localparam int ROW_W = SET_W;
   localparam int ADDR_W = ROW_W + WAYS_W;

   localparam logic OP_QUERY = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic             valid_set;
      logic [SET_W-1:0] set_index;
      logic [WAY_W-1:0] way_index;
      logic             was_hit;
   } cmd_type;

endpackage

[rtl/core/lfu_front.sv]
// ----------------------------------------------------------------------------
// LFU front end
// Accepts items, checks ranges, drops ignored updates and queues commands.
// ----------------------------------------------------------------------------
module lfu_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   in_opcode,
   input  logic [lfu_pkg::SET_W-1:0] in_set,
   input  logic [lfu_pkg::WAY_W-1:0] in_way,
   input  logic                   in_hit,
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output lfu_pkg::cmd_type       cmd
);

   lfu_pkg::cmd_type q_ff [2];
   logic [0:0] wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   lfu_pkg::cmd_type c_in;
   logic set_ok, way_ok, push, pop;

   always_comb begin
      set_ok = ({5'd0, in_set} < 16'(lfu_pkg::SETS));
      way_ok = ({1'b0, in_way} < 5'(lfu_pkg::WAYS));
      c_in.opcode = in_opcode;
      c_in.valid_set = set_ok;
      c_in.set_index = in_set;
      c_in.way_index = in_way;
      c_in.was_hit = in_hit;
   end

   assign in_ready = (cnt_ff != 2'd2);
   // Updates that fall outside the cache are swallowed here.
   assign push = in_valid && in_ready &&
                 (in_opcode == lfu_pkg::OP_QUERY || (set_ok && way_ok));
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ff];
   assign pop = cmd_valid && cmd_ready;

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= c_in;
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

[rtl/core/lfu_back.sv]
// ----------------------------------------------------------------------------
// LFU back end
// Clears the stores after reset, then serves queries and updates.
// ----------------------------------------------------------------------------
module lfu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  lfu_pkg::cmd_type            cmd,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [lfu_pkg::WAY_W-1:0]   out_way
);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_LAST, S_RMW, S_WRITE} state_type;

   logic [lfu_pkg::CNT_W-1:0]   cnt_mem   [lfu_pkg::SETS*lfu_pkg::WAYS];
   logic [lfu_pkg::STAMP_W-1:0] stamp_mem [lfu_pkg::SETS*lfu_pkg::WAYS];

   state_type state_ff;
   lfu_pkg::cmd_type cmd_ff;
   logic [lfu_pkg::ADDR_W:0] clr_ff;
   logic [lfu_pkg::WAYS_W:0] way_ff;
   logic [lfu_pkg::WAYS_W-1:0] rd_way_ff;
   logic [lfu_pkg::CNT_W-1:0] rc_ff, best_c_ff;
   logic [lfu_pkg::STAMP_W-1:0] rs_ff, best_s_ff, clk_ff;
   logic [lfu_pkg::WAYS_W-1:0] best_w_ff;
   logic first_ff;
   logic [lfu_pkg::ADDR_W-1:0] rd_addr;
   logic out_valid_ff;
   logic [lfu_pkg::WAY_W-1:0] out_way_ff;
   logic better;

   assign out_valid = out_valid_ff;
   assign out_way = out_way_ff;
   assign cmd_ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign better = first_ff || (rc_ff < best_c_ff) ||
                   (rc_ff == best_c_ff && rs_ff < best_s_ff);

   always_comb begin
      if (state_ff == S_IDLE)
         rd_addr = {cmd.set_index[lfu_pkg::ROW_W-1:0],
                    (cmd.opcode == lfu_pkg::OP_QUERY) ? lfu_pkg::WAYS_W'(0)
                    : cmd.way_index[lfu_pkg::WAYS_W-1:0]};
      else
         rd_addr = {cmd_ff.set_index[lfu_pkg::ROW_W-1:0], way_ff[lfu_pkg::WAYS_W-1:0]};
   end

   always_ff @(posedge clock) begin
      rc_ff <= cnt_mem[rd_addr];
      rs_ff <= stamp_mem[rd_addr];
      if (state_ff == S_CLEAR) begin
         cnt_mem[clr_ff[lfu_pkg::ADDR_W-1:0]] <= '0;
         stamp_mem[clr_ff[lfu_pkg::ADDR_W-1:0]] <= '0;
      end
      if (state_ff == S_WRITE) begin
         cnt_mem[{cmd_ff.set_index[lfu_pkg::ROW_W-1:0], cmd_ff.way_index[lfu_pkg::WAYS_W-1:0]}]
            <= !cmd_ff.was_hit ? lfu_pkg::CNT_W'(1)
             : (&rc_ff) ? rc_ff : rc_ff + 1'b1;
         stamp_mem[{cmd_ff.set_index[lfu_pkg::ROW_W-1:0], cmd_ff.way_index[lfu_pkg::WAYS_W-1:0]}]
            <= clk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         clk_ff <= '0;
         out_valid_ff <= 1'b0;
         way_ff <= '0;
         first_ff <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (lfu_pkg::ADDR_W+1)'(lfu_pkg::SETS*lfu_pkg::WAYS-1))
                  state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  cmd_ff <= cmd;
                  if (cmd.opcode == lfu_pkg::OP_UPDATE) begin
                     // Keep the read address on the updated way for the next read.
                     way_ff <= {1'b0, cmd.way_index[lfu_pkg::WAYS_W-1:0]};
                     state_ff <= S_RMW;
                  end else if (!cmd.valid_set) begin
                     out_way_ff <= '0;
                     out_valid_ff <= 1'b1;
                  end else begin
                     way_ff <= (lfu_pkg::WAYS_W+1)'(1);
                     rd_way_ff <= '0;
                     first_ff <= 1'b1;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // Compare the way read last cycle while the next one is read.
               first_ff <= 1'b0;
               if (better) begin
                  best_c_ff <= rc_ff;
                  best_s_ff <= rs_ff;
                  best_w_ff <= rd_way_ff;
               end
               rd_way_ff <= way_ff[lfu_pkg::WAYS_W-1:0];
               if (way_ff == (lfu_pkg::WAYS_W+1)'(lfu_pkg::WAYS-1)) state_ff <= S_LAST;
               else way_ff <= way_ff + 1'b1;
            end
            S_LAST: begin
               out_way_ff <= lfu_pkg::WAY_W'(better ? rd_way_ff : best_w_ff);
               out_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_RMW: begin
               clk_ff <= clk_ff + 1'b1;
               state_ff <= S_WRITE;
            end
            S_WRITE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/core/lfu_lru_tiebreak_replacement_core.sv]
// ----------------------------------------------------------------------------
// LFU replacement core with LRU tie-break
// Use counts and access stamps per way; victim query picks the lowest count.
// ----------------------------------------------------------------------------
// A query reads and compares every way of the set, one way read per cycle from the
// single read address of the count/stamp memories, before its result is valid; an update
// is read, modified and written back through the S_IDLE, S_RMW and S_WRITE states.
// The back end takes no new item until the last one is through and any result is taken.
// Reset is synchronous; afterwards a clearing pass over all SETS*WAYS = 32768 entries zeroes
// the stores; up to two items are queued meanwhile, and none is served until it is done.
module lfu_lru_tiebreak_replacement_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: opcode[0], set_index[11:1], way_index[15:12], was_hit[16], zero fill.
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: evict_way[3:0], zero fill.
   output logic [7:0]  rsp_tdata
);

   logic cmd_valid, cmd_ready;
   lfu_pkg::cmd_type cmd;
   logic [lfu_pkg::WAY_W-1:0] way;

   // The front end classifies and queues; the back end owns the memories.
   lfu_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_opcode(req_tdata[0]), .in_set(req_tdata[11:1]),
      .in_way(req_tdata[15:12]), .in_hit(req_tdata[16]),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
   );

   lfu_back u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_way(way)
   );

   assign rsp_tdata = {4'd0, way};

endmodule
